@@ hdl/nec_ir_edge_decoder_assert.svh @@
// Assertion macros shared by the NEC IR edge decoder modules.
// Each macro expects the signals aclk and aresetn in the including module.
`ifndef NEC_IR_EDGE_DECODER_ASSERT_SVH
`define NEC_IR_EDGE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NIR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/nir_pkg.sv @@
// Types and timing constants for the NEC IR edge decoder.
// No dependencies; imported by every module of the decoder.
package nir_pkg;

    localparam logic [1:0] KIND_EDGE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        level;
        logic [31:0] stamp;
    } in_word_t;

    typedef struct packed {
        logic [31:0] message;
        logic [5:0]  bit_count;
    } out_word_t;

    typedef struct packed {
        logic [15:0] gap;
        logic        rpt_window;
    } gap_info_t;

    // All gaps are in microseconds (stamp ticks halved).
    localparam logic [15:0] GAP_NEW_FRAME = 16'd30000;
    localparam logic [15:0] RPT_LO        = 16'd2000;
    localparam logic [15:0] RPT_HI        = 16'd2500;
    localparam logic [15:0] START_LO      = 16'd4000;
    localparam logic [15:0] START_HI      = 16'd5000;
    localparam logic [15:0] BIT_MIN       = 16'd400;
    localparam logic [15:0] BIT_MAX       = 16'd1880;
    localparam logic [15:0] BIT_BAD_LO    = 16'd800;
    localparam logic [15:0] BIT_BAD_HI    = 16'd1400;
    localparam logic [15:0] BIT_ONE       = 16'd1000;
    localparam logic [15:0] RISE_ABORT    = 16'd11000;
    localparam logic [15:0] MARK_MIN      = 16'd300;
    localparam logic [15:0] MARK_MAX      = 16'd750;
    localparam logic [15:0] TICK_ABORT    = 16'd10000;

    // Repeat window is in raw stamp ticks.
    localparam logic [31:0] REPEAT_WINDOW = 32'd262144;

    localparam logic [5:0]  BITS_FRAME    = 6'd32;
    localparam logic [5:0]  BITS_REPEAT   = 6'd1;

endpackage

@@ hdl/nir_gap.sv @@
// Gap measurement: time since the last edge and the repeat-window test.
// Depends on nir_pkg.
module nir_gap
    import nir_pkg::*;
(
    input  logic [31:0] stamp,
    input  logic [31:0] last_edge_time,
    input  logic [31:0] last_frame_time,
    output gap_info_t   info
);

    logic [31:0] diff;
    logic [31:0] neg_diff;
    logic [31:0] frame_diff;

    assign diff       = stamp - last_edge_time;
    assign neg_diff   = 32'd0 - diff;
    assign frame_diff = stamp - last_frame_time;

    // A negative difference is halved toward zero and keeps its low 16 bits.
    always_comb begin
        if (!diff[31]) begin
            info.gap = (|diff[31:17]) ? 16'hFFFF : diff[16:1];
        end else begin
            info.gap = 16'd0 - neg_diff[16:1];
        end
        info.rpt_window = frame_diff[31] || (frame_diff < REPEAT_WINDOW);
    end

endmodule

@@ hdl/nir_core.sv @@
// Frame decoder state: phase, bit shifter, edge history and held capture.
// Depends on nir_pkg, nir_gap and the assertion macro header.
`include "nec_ir_edge_decoder_assert.svh"

module nir_core
    import nir_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_word_t  word,
    output out_word_t result
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  bits_taken_reg, bits_taken_next;
    logic [31:0] shift_or_time_reg, shift_or_time_next;
    logic [31:0] last_edge_time_reg, last_edge_time_next;
    logic        pin_level_reg, pin_level_next;
    logic [31:0] held_frame_reg, held_frame_next;
    logic [5:0]  held_count_reg, held_count_next;

    gap_info_t   ginfo;
    logic [15:0] gap;
    logic        edge_evt;
    logic        fall;
    logic        rise;
    logic        tick;
    logic        rd;
    logic        new_frame;
    logic        rpt_gap;
    logic        start_gap;
    logic        bit_gap_ok;
    logic        start_ok;
    logic        repeat_hit;
    logic        take_bit;
    logic        last_bit;
    logic [31:0] shift_with_bit;

    nir_gap u_gap (
        .stamp           (word.stamp),
        .last_edge_time  (last_edge_time_reg),
        .last_frame_time (shift_or_time_reg),
        .info            (ginfo)
    );

    assign gap = ginfo.gap;

    // An edge that repeats the current level is dropped without a trace.
    assign edge_evt  = fire && (word.kind == KIND_EDGE) && (word.level != pin_level_reg);
    assign fall      = edge_evt && !word.level;
    assign rise      = edge_evt && word.level;
    assign tick      = fire && (word.kind == KIND_TICK);
    assign rd        = fire && (word.kind == KIND_READ);

    assign new_frame  = (phase_reg == PH_IDLE) || (gap >= GAP_NEW_FRAME);
    assign rpt_gap    = (gap > RPT_LO) && (gap < RPT_HI);
    assign start_gap  = (gap >= START_LO) && (gap <= START_HI);
    assign bit_gap_ok = (gap >= BIT_MIN) && (gap <= BIT_MAX)
                        && !((gap > BIT_BAD_LO) && (gap < BIT_BAD_HI));

    assign start_ok   = fall && !new_frame && (phase_reg == PH_START) && !rpt_gap && start_gap;
    assign repeat_hit = fall && !new_frame && (phase_reg == PH_START) && rpt_gap
                        && ginfo.rpt_window;
    assign take_bit   = fall && !new_frame && (phase_reg == PH_DATA) && bit_gap_ok
                        && (bits_taken_reg < BITS_FRAME);
    assign last_bit   = take_bit && (bits_taken_reg == BITS_FRAME - 6'd1);

    assign shift_with_bit = (gap > BIT_ONE)
                            ? (shift_or_time_reg | (32'h8000_0000 >> bits_taken_reg[4:0]))
                            : shift_or_time_reg;

    always_comb begin
        phase_next = phase_reg;
        priority if (fall) begin
            priority if (new_frame) begin
                phase_next = PH_START;
            end else if (phase_reg == PH_START) begin
                if (!rpt_gap) begin
                    phase_next = start_gap ? PH_DATA : PH_IDLE;
                end
            end else if (phase_reg != PH_DATA) begin
                phase_next = PH_IDLE;
            end else if (!bit_gap_ok) begin
                phase_next = PH_IDLE;
            end else if (last_bit) begin
                phase_next = PH_IDLE;
            end else begin
                phase_next = phase_reg;
            end
        end else if (rise) begin
            if ((gap > RISE_ABORT)
                || ((phase_reg == PH_DATA) && ((gap < MARK_MIN) || (gap > MARK_MAX)))) begin
                phase_next = PH_IDLE;
            end
        end else if (tick) begin
            if ((phase_reg != PH_IDLE) && (gap > TICK_ABORT)) begin
                phase_next = PH_IDLE;
            end
        end else begin
            phase_next = phase_reg;
        end
    end

    always_comb begin
        bits_taken_next     = bits_taken_reg;
        shift_or_time_next  = shift_or_time_reg;
        last_edge_time_next = last_edge_time_reg;
        pin_level_next      = pin_level_reg;
        held_frame_next     = held_frame_reg;
        held_count_next     = held_count_reg;

        if (edge_evt) begin
            last_edge_time_next = word.stamp;
            pin_level_next      = word.level;
        end

        if (fall && new_frame) begin
            bits_taken_next = 6'd0;
        end else if (take_bit) begin
            bits_taken_next = bits_taken_reg + 6'd1;
        end

        // After a completed frame or an accepted repeat the shifter holds its
        // time stamp, which the repeat-window test reads.
        priority if (start_ok) begin
            shift_or_time_next = 32'd0;
        end else if (repeat_hit || last_bit) begin
            shift_or_time_next = word.stamp;
        end else if (take_bit) begin
            shift_or_time_next = shift_with_bit;
        end else begin
            shift_or_time_next = shift_or_time_reg;
        end

        priority if (rd) begin
            held_frame_next = 32'd0;
            held_count_next = 6'd0;
        end else if (last_bit) begin
            held_frame_next = shift_with_bit;
            held_count_next = BITS_FRAME;
        end else if (repeat_hit && (held_count_reg == 6'd0)) begin
            held_frame_next = 32'd1;
            held_count_next = BITS_REPEAT;
        end else begin
            held_frame_next = held_frame_reg;
            held_count_next = held_count_reg;
        end

        result.message   = (held_count_reg == 6'd0) ? 32'd0 : held_frame_reg;
        result.bit_count = held_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            bits_taken_reg     <= 6'd0;
            shift_or_time_reg  <= 32'd0;
            last_edge_time_reg <= 32'd0;
            pin_level_reg      <= 1'b1;
            held_frame_reg     <= 32'd0;
            held_count_reg     <= 6'd0;
        end else begin
            phase_reg          <= phase_next;
            bits_taken_reg     <= bits_taken_next;
            shift_or_time_reg  <= shift_or_time_next;
            last_edge_time_reg <= last_edge_time_next;
            pin_level_reg      <= pin_level_next;
            held_frame_reg     <= held_frame_next;
            held_count_reg     <= held_count_next;
        end
    end

    `NIR_ASSERT_SAME(a_data_count_in_range, phase_reg == PH_DATA,
        bits_taken_reg < BITS_FRAME, "bit counter overran the frame while collecting")
    `NIR_ASSERT_SAME(a_empty_capture_clear, held_count_reg == 6'd0,
        held_frame_reg == 32'd0, "held frame is nonzero with no capture held")
    `NIR_ASSERT_NEXT(a_last_bit_holds_frame, last_bit,
        (held_count_reg == BITS_FRAME) && (phase_reg == PH_IDLE),
        "completed frame was not captured")

endmodule

@@ hdl/nec_ir_edge_decoder.sv @@
// Top level of the NEC IR edge decoder: input register, decoder core, result register.
// Depends on nir_pkg, nir_core and the assertion macro header.
//
//   channel   direction   handshake            payload
//   s_        in          s_valid / s_ready    s_data  (in_word_t: kind, level, stamp)
//   m_        out         m_valid / m_ready    m_data  (out_word_t: message, bit_count)
//
// Every word is registered in the input register and decoded from there;
// a read word's result is loaded into the result register at the edge that decodes it.
// One word per cycle is sustained while no read word waits on an untaken result.
// A read word waits in the input register only while an earlier result is still untaken.
// Reset is synchronous and active low; it returns the decoder to idle with the line high.
`include "nec_ir_edge_decoder_assert.svh"

module nec_ir_edge_decoder
    import nir_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      in_valid_reg, in_valid_next;
    in_word_t  in_word_reg;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg;
    out_word_t core_result;
    logic      out_free;
    logic      is_read;
    logic      fire;
    logic      take_in;

    assign out_free = !m_valid_reg || m_ready;
    assign is_read  = (in_word_reg.kind == KIND_READ);
    assign fire     = in_valid_reg && (!is_read || out_free);
    assign s_ready  = !in_valid_reg || fire;
    assign take_in  = s_valid && s_ready;

    nir_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .word    (in_word_reg),
        .result  (core_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take_in) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (fire && is_read) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_word_reg <= s_data;
        end
        if (fire && is_read) begin
            m_data_reg <= core_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `NIR_ASSERT_NEXT(a_read_gives_result, fire && is_read, m_valid_reg,
        "read word did not produce a result")
    `NIR_ASSERT_SAME(a_read_never_overwrites, fire && is_read, out_free,
        "read decoded while an untaken result was pending")
    `NIR_ASSERT_SAME(a_count_legal, m_valid_reg,
        (m_data_reg.bit_count == 6'd0) || (m_data_reg.bit_count == BITS_REPEAT)
        || (m_data_reg.bit_count == BITS_FRAME), "result bit count is not 0, 1 or 32")
    `NIR_ASSERT_SAME(a_empty_result_zero, m_valid_reg && (m_data_reg.bit_count == 6'd0),
        m_data_reg.message == 32'd0, "empty result carries a nonzero message")

endmodule
